>>> rtl/core/rag_pkg.sv
package rag_pkg;

    localparam int OPW = 32;
    localparam int DW  = 64;

    typedef enum logic [2:0] {
        MODE_ADD    = 3'd0,
        MODE_SUB    = 3'd1,
        MODE_MUL    = 3'd2,
        MODE_DIV    = 3'd3,
        MODE_REDUCE = 3'd4,
        MODE_CMP    = 3'd5
    } mode_t;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               div_zero;
        logic               overflow;
        logic               less;
        logic               equal;
        logic               greater;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_COMBINE,
        ST_GCD_START,
        ST_GCD_DIV,
        ST_DIVN_START,
        ST_DIVN,
        ST_DIVD_START,
        ST_DIVD,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

>>> rtl/core/rag_divider.sv
module rag_divider
    import rag_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [DW-1:0] quotient,
    output logic [DW-1:0] remainder,
    output logic          busy
);

    logic [DW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic [DW:0]   shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg | start;

endmodule

>>> rtl/core/rational_alu_with_gcd_reduce_core.sv
// Rational ALU: add, subtract, multiply, divide, reduce or compare two fractions. Each item
// is taken over a valid/ready transfer and one result comes back on the output channel.
// The block works on one item at a time: one shared 33x33 signed multiplier forms the cross
// products in ST_MUL1, ST_MUL2 and ST_MUL3, then one shared bit-serial 64-bit divider runs
// the Euclidean gcd, one remainder step per pass through ST_GCD_START and ST_GCD_DIV, and
// then divides the numerator and the denominator by the gcd. Compare, division-by-zero and
// unused-mode cases finish right after the products. in_ready is high only while the block is idle.
module rational_alu_with_gcd_reduce_core
    import rag_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [DW-1:0] LIM = (DW'(1) << (WIDTH - 1)) - DW'(1);

    state_t state_reg, state_next;
    in_item_t  item_reg;
    out_item_t res_reg, res_next;
    logic signed [DW-1:0] p1_reg, p2_reg, p3_reg, n_reg, d_reg;
    logic [DW-1:0] x_reg, y_reg, mn_reg, md_reg, g_reg;
    logic signed [DW-1:0] n_next, d_next;
    logic [DW-1:0] x_next, y_next, mn_next, md_next, g_next;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic signed [DW-1:0] mul_q;
    logic div_start;
    logic div_busy;
    logic [DW-1:0] div_dividend, div_divisor, quo, rem;
    logic neg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL1:
            begin
                mul_a = 33'(item_reg.a_num);
                mul_b = (item_reg.mode == MODE_MUL) ? 33'(item_reg.b_num)
                                                      : $signed({2'b0, item_reg.b_den});
            end
            ST_MUL2:
            begin
                mul_a = 33'(item_reg.a_den);
                mul_b = (item_reg.mode == MODE_DIV) ? $signed({2'b0, item_reg.b_den})
                                                      : 33'(item_reg.b_num);
            end
            ST_MUL3:
            begin
                mul_a = (item_reg.mode == MODE_DIV) ? 33'(item_reg.a_den)
                                                      : 33'(item_reg.a_den);
                mul_b = (item_reg.mode == MODE_DIV) ? 33'(item_reg.b_num)
                                                      : $signed({2'b0, item_reg.b_den});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
        mul_q = mul_p[DW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL1;
            ST_MUL1:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_MUL3;
            ST_MUL3:       state_next = ST_COMBINE;
            ST_COMBINE:
            begin
                if (item_reg.mode == MODE_CMP || item_reg.mode > MODE_CMP
                    || d_next == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_GCD_START;
            end
            ST_GCD_START:  state_next = (y_reg == '0) ? ST_DIVN_START : ST_GCD_DIV;
            ST_GCD_DIV:    if (!div_busy) state_next = ST_GCD_START;
            ST_DIVN_START: state_next = ST_DIVN;
            ST_DIVN:       if (!div_busy) state_next = ST_DIVD_START;
            ST_DIVD_START: state_next = ST_DIVD;
            ST_DIVD:       if (!div_busy) state_next = ST_FINISH;
            ST_FINISH:     state_next = ST_OUT;
            ST_OUT:        if (out_ready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        n_next  = n_reg;
        d_next  = d_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        mn_next = mn_reg;
        md_next = md_reg;
        g_next  = g_reg;
        res_next = res_reg;
        div_start = 1'b0;
        div_dividend = x_reg;
        div_divisor  = y_reg;
        neg = (mn_reg != '0) && ((n_reg < 0) != (d_reg < 0));
        unique case (state_reg)
            ST_COMBINE:
            begin
                unique case (item_reg.mode)
                    MODE_ADD:    begin n_next = p1_reg + p2_reg; d_next = p3_reg; end
                    MODE_SUB:    begin n_next = p1_reg - p2_reg; d_next = p3_reg; end
                    MODE_MUL:    begin n_next = p1_reg; d_next = p3_reg; end
                    MODE_DIV:    begin n_next = p1_reg; d_next = p3_reg; end
                    MODE_REDUCE:
                    begin
                        n_next = DW'(item_reg.a_num);
                        d_next = DW'(item_reg.a_den);
                    end
                    default:     begin n_next = '0; d_next = '0; end
                endcase
                res_next = '0;
                if (item_reg.mode == MODE_CMP)
                begin
                    if (item_reg.a_den == '0 || item_reg.b_den == '0)
                        res_next.div_zero = 1'b1;
                    else if (p1_reg == p2_reg)
                        res_next.equal = 1'b1;
                    else if ((p1_reg < p2_reg) != item_reg.a_den[31])
                        res_next.less = 1'b1;
                    else
                        res_next.greater = 1'b1;
                end
                else if (item_reg.mode <= MODE_REDUCE && d_next == '0)
                    res_next.div_zero = 1'b1;
                mn_next = n_next[DW-1] ? -n_next : n_next;
                md_next = d_next[DW-1] ? -d_next : d_next;
                x_next  = mn_next;
                y_next  = md_next;
            end
            ST_GCD_START:
            begin
                if (y_reg != '0)
                    div_start = 1'b1;
                else
                    g_next = x_reg;
            end
            ST_GCD_DIV:
            begin
                if (!div_busy)
                begin
                    x_next = y_reg;
                    y_next = rem;
                end
            end
            ST_DIVN_START:
            begin
                div_start = 1'b1;
                div_dividend = mn_reg;
                div_divisor  = g_reg;
            end
            ST_DIVN:       if (!div_busy) mn_next = quo;
            ST_DIVD_START:
            begin
                div_start = 1'b1;
                div_dividend = md_reg;
                div_divisor  = g_reg;
            end
            ST_DIVD:       if (!div_busy) md_next = quo;
            ST_FINISH:
            begin
                res_next = '0;
                if (md_reg > LIM || mn_reg > LIM + DW'(neg))
                    res_next.overflow = 1'b1;
                else
                begin
                    res_next.res_num = neg ? 32'(-mn_reg) : 32'(mn_reg);
                    res_next.res_den = md_reg[30:0];
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    rag_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (quo),
        .remainder (rem),
        .busy      (div_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
            item_reg <= in_data;
        if (state_reg == ST_MUL1) p1_reg <= mul_q;
        if (state_reg == ST_MUL2) p2_reg <= mul_q;
        if (state_reg == ST_MUL3) p3_reg <= mul_q;
        n_reg   <= n_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        mn_reg  <= mn_next;
        md_reg  <= md_next;
        g_reg   <= g_next;
        res_reg <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = res_reg;

endmodule

>>> dv/rational_alu_with_gcd_reduce_core_test.sv
`timescale 1ns / 1ps

module rational_alu_with_gcd_reduce_core_test;
    import rag_pkg::*;

    localparam int WIDTH = 32;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int RAND_PER_PHASE = 270;
    localparam longint CYCLE_LIMIT = 60_000_000;
    localparam int HOLD_OFF_CYCLES = 600;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_data;

    in_item_t  pending_q[$];
    out_item_t fraction_q[$];
    bit        in_fire = 1'b0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_gen = 0;
    int        hold_seen = 0;
    int        hold_cnt = 0;
    int        errors = 0;
    int        results_seen = 0;
    int        mode_cnt[8];
    int        dz_cnt = 0;
    int        ovf_cnt = 0;
    longint    cycles = 0;

    rational_alu_with_gcd_reduce_core #(.WIDTH(WIDTH)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_item_t predict_fraction(in_item_t it);
        out_item_t         r;
        longint            an, ad, bn, bd, n, d, lhs, rhs;
        longint unsigned   mn, md, x, y, t, lim;
        bit                neg;
        bit                flip;
        r = '0;
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = longint'({33'b0, it.b_den});
        n = 0;
        d = 0;
        case (it.mode)
            MODE_ADD:
            begin
                n = an * bd + ad * bn;
                d = ad * bd;
            end
            MODE_SUB:
            begin
                n = an * bd - ad * bn;
                d = ad * bd;
            end
            MODE_MUL:
            begin
                n = an * bn;
                d = ad * bd;
            end
            MODE_DIV:
            begin
                n = an * bd;
                d = ad * bn;
            end
            MODE_REDUCE:
            begin
                n = an;
                d = ad;
            end
            MODE_CMP:
            begin
                if (ad == 0 || bd == 0)
                begin
                    r.div_zero = 1'b1;
                    return r;
                end
                lhs = an * bd;
                rhs = bn * ad;
                flip = (ad < 0);
                if (lhs == rhs)
                    r.equal = 1'b1;
                else if ((lhs < rhs) != flip)
                    r.less = 1'b1;
                else
                    r.greater = 1'b1;
                return r;
            end
            default:
                return r;
        endcase
        if (d == 0)
        begin
            r.div_zero = 1'b1;
            return r;
        end
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        x = mn;
        y = md;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        mn = mn / x;
        md = md / x;
        neg = (mn != 0) && ((n < 0) != (d < 0));
        lim = (64'd1 << (WIDTH - 1)) - 1;
        if (md > lim || mn > lim + (neg ? 1 : 0))
        begin
            r.overflow = 1'b1;
            return r;
        end
        r.res_num = neg ? 32'(-mn) : 32'(mn);
        r.res_den = md[30:0];
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        logic [31:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(40) - 20;
            4, 5: v = $urandom_range(131070) - 65535;
            6: v = $urandom;
            7:
            begin
                case ($urandom_range(5))
                    0: v = 32'h7fff_ffff;
                    1: v = 32'h8000_0000;
                    2: v = 32'h8000_0001;
                    3: v = 32'd1;
                    4: v = 32'hffff_ffff;
                    default: v = 32'd0;
                endcase
            end
            default:
            begin
                v = $urandom_range(50, 1) << $urandom_range(24);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    task automatic push_item(logic [2:0] m, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [30:0] bd);
        in_item_t it;
        it.mode = m;
        it.a_num = an;
        it.a_den = ad;
        it.b_num = bn;
        it.b_den = bd;
        pending_q.push_back(it);
    endtask

    task automatic push_random();
        logic [2:0]  m;
        logic [31:0] bdw;
        if ($urandom_range(99) < 4)
            m = $urandom_range(1) ? MODE_SPARE6 : MODE_SPARE7;
        else
            m = 3'($urandom_range(5));
        bdw = pick_word();
        if (bdw[31] && $urandom_range(3) != 0)
            bdw = -bdw;
        push_item(m, pick_word(), pick_word(), pick_word(), bdw[30:0]);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (errors < 30)
            $display("mismatch %s: got %0h expected %0h (result %0d)",
                     what, got, want, results_seen);
        errors++;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || fraction_q.size() != 0 || in_valid)
            @(posedge clk);
    endtask

    // input side: capture transfers and queue predictions
    always @(posedge clk)
    begin
        cycles++;
        in_fire = in_valid && in_ready;
        if (in_fire)
        begin
            fraction_q.push_back(predict_fraction(in_data));
            mode_cnt[in_data.mode]++;
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_data <= pending_q.pop_front();
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver with long hold-off on request
    always @(negedge clk)
    begin
        if (hold_gen != hold_seen)
        begin
            hold_seen = hold_gen;
            hold_cnt = HOLD_OFF_CYCLES;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (fraction_q.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(out_data), '0);
            end
            else
            begin
                want = fraction_q.pop_front();
                if (out_data.res_num !== want.res_num)
                    report_mismatch("res_num", 64'(out_data.res_num), 64'(want.res_num));
                if (out_data.res_den !== want.res_den)
                    report_mismatch("res_den", 64'(out_data.res_den), 64'(want.res_den));
                if (out_data.div_zero !== want.div_zero)
                    report_mismatch("div_zero", 64'(out_data.div_zero),
                                    64'(want.div_zero));
                if (out_data.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(out_data.overflow),
                                    64'(want.overflow));
                if (out_data.less !== want.less)
                    report_mismatch("less", 64'(out_data.less), 64'(want.less));
                if (out_data.equal !== want.equal)
                    report_mismatch("equal", 64'(out_data.equal), 64'(want.equal));
                if (out_data.greater !== want.greater)
                    report_mismatch("greater", 64'(out_data.greater), 64'(want.greater));
                dz_cnt += want.div_zero;
                ovf_cnt += want.overflow;
            end
        end
    end

    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        int drain;
        idle_tab = '{0, 85, 0, 16};
        stall_tab = '{0, 0, 85, 16};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes and special cases
        push_item(MODE_ADD, 32'd1, 32'd2, 32'd1, 31'd3);
        push_item(MODE_SUB, 32'd1, 32'd2, 32'd1, 31'd2);
        push_item(MODE_MUL, -32'sd3, 32'd4, 32'd8, 31'd9);
        push_item(MODE_DIV, 32'd3, 32'd4, -32'sd6, 31'd5);
        push_item(MODE_DIV, 32'd3, 32'd4, 32'd0, 31'd5);
        push_item(MODE_REDUCE, 32'd12, -32'sd18, 32'd0, 31'd0);
        push_item(MODE_REDUCE, 32'd0, -32'sd7, 32'hffff_ffff, 31'h7fff_ffff);
        push_item(MODE_REDUCE, 32'd5, 32'd0, 32'd0, 31'd1);
        push_item(MODE_ADD, 32'd5, 32'd7, 32'd1, 31'd0);
        push_item(MODE_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 31'd1);
        push_item(MODE_SUB, 32'h8000_0000, 32'd1, 32'd0, 31'd1);
        push_item(MODE_SUB, 32'h8000_0000, 32'd1, 32'd1, 31'd1);
        push_item(MODE_MUL, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
        push_item(MODE_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 31'h7fff_ffff);
        push_item(MODE_REDUCE, 32'h8000_0000, -32'sd1, 32'd0, 31'd0);
        push_item(MODE_REDUCE, 32'h8000_0000, 32'h8000_0001, 32'd0, 31'd0);
        push_item(MODE_ADD, 32'd1, -32'sd3, 32'd1, 31'd6);
        push_item(MODE_CMP, 32'd1, 32'd2, 32'd2, 31'd4);
        push_item(MODE_CMP, 32'd1, 32'd3, 32'd1, 31'd2);
        push_item(MODE_CMP, 32'd1, -32'sd3, -32'sd1, 31'd2);
        push_item(MODE_CMP, 32'd1, 32'd0, 32'd1, 31'd2);
        push_item(MODE_CMP, 32'd1, 32'd5, 32'd1, 31'd0);
        push_item(MODE_CMP, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
        push_item(MODE_SPARE6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
        push_item(MODE_SPARE7, 32'd3, 32'd4, 32'd5, 31'd6);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_tab[p];
            recv_stall_pct = stall_tab[p];
            for (int i = 0; i < RAND_PER_PHASE; i++)
                push_random();
            if (p == 0)
            begin
                while (pending_q.size() > RAND_PER_PHASE - 5)
                    @(posedge clk);
                hold_gen++;
            end
            wait_drained();
        end

        drain = 0;
        while (drain < 300)
        begin
            @(posedge clk);
            drain++;
        end
        $display("ran %0d results over %0d cycles: add %0d sub %0d mul %0d div %0d",
                 results_seen, cycles, mode_cnt[0], mode_cnt[1], mode_cnt[2], mode_cnt[3]);
        $display("reduce %0d compare %0d spare %0d, div-by-zero %0d, overflow %0d",
                 mode_cnt[4], mode_cnt[5], mode_cnt[6] + mode_cnt[7], dz_cnt, ovf_cnt);
        if (errors == 0 && fraction_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
